FILE: sv/sbie_pkg.sv
// Package for the integer stack-bytecode executor: opcodes, fault codes,
// default sizes and the shared cell control struct. No dependencies.
package sbie_pkg;

  localparam int StackDepthDef = 64;
  localparam int LocalSlotsDef = 16;
  localparam int WordBitsDef   = 32;
  localparam int DepthW        = 7;
  localparam int OpW           = 5;
  localparam int ImmW          = 32;
  localparam int FaultW        = 3;

  typedef enum logic [OpW-1:0] {
    OP_PUSHC = 5'd0, OP_NIL = 5'd1, OP_STLOC = 5'd2, OP_LDLOC = 5'd3,
    OP_LDREF = 5'd4, OP_MUL = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7,
    OP_DIV = 5'd8, OP_REM = 5'd9, OP_NEG = 5'd10, OP_AND = 5'd11,
    OP_IFLE = 5'd12, OP_GOTO = 5'd13, OP_CGT = 5'd14, OP_CGE = 5'd15,
    OP_CLT = 5'd16, OP_CLE = 5'd17, OP_CNE = 5'd18, OP_CEQ = 5'd19,
    OP_DUP = 5'd20, OP_IRET = 5'd21, OP_RET = 5'd22
  } op_e;

  typedef enum logic [FaultW-1:0] {
    FLT_NONE = 3'd0, FLT_UNDER = 3'd1, FLT_OVER = 3'd2,
    FLT_DIVZ = 3'd3, FLT_LOCAL = 3'd4
  } fault_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_OUT
  } state_e;

  // stack shift control for the cell row
  typedef struct packed {
    logic push;    // shift everything down one place, load top
    logic pop;     // shift everything up one place
    logic wr_top;  // overwrite the top cell (after any pop)
  } shift_t;

endpackage

FILE: sv/sbie_cell.sv
// One stack cell of the executor: holds one word and moves with its neighbors.
// Depends on sbie_pkg for the shift control struct.
module sbie_cell #(
  parameter int WordBits = sbie_pkg::WordBitsDef
) (
  input  logic                clk_i,
  input  sbie_pkg::shift_t    ctl_i,
  input  logic                is_top_i,
  input  logic [WordBits-1:0] top_i,
  input  logic [WordBits-1:0] above_i,
  input  logic [WordBits-1:0] below_i,
  output logic [WordBits-1:0] word_o
);
  logic [WordBits-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.push) begin
      word_d = is_top_i ? top_i : above_i;
    end else if (ctl_i.pop) begin
      word_d = (is_top_i && ctl_i.wr_top) ? top_i : below_i;
    end else if (ctl_i.wr_top && is_top_i) begin
      word_d = top_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
endmodule

FILE: sv/sbie_div.sv
// Radix-2 restoring divider for signed truncating division and remainder.
// Depends on sbie_pkg for the default word width; one quotient bit a cycle.
module sbie_div #(
  parameter int WordBits = sbie_pkg::WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] num_i,
  input  logic [WordBits-1:0] den_i,
  output logic                done_o,
  output logic [WordBits-1:0] quo_o,
  output logic [WordBits-1:0] rem_o
);
  localparam int CntW = $clog2(WordBits + 1);

  logic [WordBits-1:0] q_q, d_q;
  logic [WordBits:0]   r_q;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q, nneg_q, qneg_q;
  logic [WordBits:0]   trial;
  logic [WordBits:0]   shifted;

  assign shifted = {r_q[WordBits-1:0], q_q[WordBits-1]};
  assign trial   = shifted - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(WordBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q    <= num_i[WordBits-1] ? -num_i : num_i;
      d_q    <= den_i[WordBits-1] ? -den_i : den_i;
      r_q    <= '0;
      nneg_q <= num_i[WordBits-1];
      qneg_q <= num_i[WordBits-1] ^ den_i[WordBits-1];
    end else if (busy_q) begin
      if (!trial[WordBits]) begin
        r_q <= trial;
        q_q <= {q_q[WordBits-2:0], 1'b1};
      end else begin
        r_q <= shifted;
        q_q <= {q_q[WordBits-2:0], 1'b0};
      end
    end
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  // final step value, used directly on done
  logic [WordBits-1:0] qf, rf;
  assign qf    = {q_q[WordBits-2:0], ~trial[WordBits]};
  assign rf    = trial[WordBits] ? shifted[WordBits-1:0] : trial[WordBits-1:0];
  assign quo_o = qneg_q ? -qf : qf;
  assign rem_o = nneg_q ? -rf : rf;
endmodule

FILE: sv/stack_bytecode_integer_executor.sv
// Top level of the integer stack-bytecode executor: control, locals, cell row.
// Depends on sbie_pkg, sbie_cell and sbie_div.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i/in_stall_o   | op_i, imm_i
//  out     | output    | out_valid_o/out_stall_i | top_value_o .. fault_o
//
// A beat is taken only when idle; an execute state follows, then the result
// beat is offered in the output state, and the next beat is taken once the
// output state returns to idle: one bytecode is in flight at a time.
// div and rem add a divide state, run by the one-bit-a-cycle divider.
// Reset clears the stack count and all locals; stack cells are not reset.
// A result held under out_stall_i blocks the next beat on the input.
module stack_bytecode_integer_executor #(
  parameter int StackDepth = sbie_pkg::StackDepthDef,
  parameter int LocalSlots = sbie_pkg::LocalSlotsDef,
  parameter int WordBits   = sbie_pkg::WordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sbie_pkg::OpW-1:0]      op_i,
  input  logic signed [sbie_pkg::ImmW-1:0] imm_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            top_value_o,
  output logic [sbie_pkg::DepthW-1:0]   depth_o,
  output logic                          branch_taken_o,
  output logic                          returned_o,
  output logic signed [31:0]            return_value_o,
  output logic [sbie_pkg::FaultW-1:0]   fault_o
);
  localparam int CntW = $clog2(StackDepth + 1);
  localparam int LocW = (LocalSlots > 1) ? $clog2(LocalSlots) : 1;
  localparam int Dw   = sbie_pkg::DepthW;

  sbie_pkg::state_e state_q, state_d;
  logic [sbie_pkg::OpW-1:0] op_q;
  logic [sbie_pkg::ImmW-1:0] imm_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [WordBits-1:0] loc_q [LocalSlots];
  logic [WordBits-1:0] cells [StackDepth];
  sbie_pkg::shift_t ctl;
  logic [WordBits-1:0] top_new;
  logic [WordBits-1:0] t0, t1;
  logic taken_q, taken_d, ret_q, ret_d;
  logic [WordBits-1:0] rv_q, rv_d;
  logic [sbie_pkg::FaultW-1:0] flt_q, flt_d;
  logic idx_ok;
  logic [LocW-1:0] idx;
  logic loc_we;
  logic div_start, div_done;
  logic [WordBits-1:0] quo, rem;
  logic accept;

  // the top two entries sit at fixed cells 0 and 1
  assign t0 = cells[0];
  assign t1 = cells[StackDepth > 1 ? 1 : 0];

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != sbie_pkg::ST_IDLE);

  assign idx_ok = !imm_q[sbie_pkg::ImmW-1] &&
                  ({1'b0, imm_q[sbie_pkg::ImmW-2:0]} < sbie_pkg::ImmW'(LocalSlots));
  assign idx = imm_q[LocW-1:0];

  for (genvar g = 0; g < StackDepth; g++) begin : g_cell
    sbie_cell #(.WordBits(WordBits)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .is_top_i(g == 0),
      .top_i   (top_new),
      .above_i (cells[g == 0 ? 0 : g - 1]),
      .below_i (cells[g == StackDepth - 1 ? g : g + 1]),
      .word_o  (cells[g])
    );
  end

  sbie_div #(.WordBits(WordBits)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (t1),
    .den_i  (t0),
    .done_o (div_done),
    .quo_o  (quo),
    .rem_o  (rem)
  );

  function automatic logic slt(input logic [WordBits-1:0] a, input logic [WordBits-1:0] b);
    slt = $signed(a) < $signed(b);
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbie_pkg::ST_IDLE: if (accept) state_d = sbie_pkg::ST_EXEC;
      sbie_pkg::ST_EXEC: begin
        if ((op_q == sbie_pkg::OP_DIV || op_q == sbie_pkg::OP_REM) && cnt_q >= CntW'(2)
            && t0 != '0) begin
          state_d = sbie_pkg::ST_DIV;
        end else begin
          state_d = sbie_pkg::ST_OUT;
        end
      end
      sbie_pkg::ST_DIV: if (div_done) state_d = sbie_pkg::ST_OUT;
      sbie_pkg::ST_OUT: if (!out_stall_i) state_d = sbie_pkg::ST_IDLE;
      default: state_d = sbie_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    top_new   = '0;
    cnt_d     = cnt_q;
    taken_d   = taken_q;
    ret_d     = ret_q;
    rv_d      = rv_q;
    flt_d     = flt_q;
    loc_we    = 1'b0;
    div_start = 1'b0;
    if (state_q == sbie_pkg::ST_EXEC) begin
      taken_d = 1'b0;
      ret_d   = 1'b0;
      rv_d    = '0;
      flt_d   = sbie_pkg::FLT_NONE;
      case (op_q)
        sbie_pkg::OP_PUSHC, sbie_pkg::OP_NIL, sbie_pkg::OP_LDLOC,
        sbie_pkg::OP_LDREF, sbie_pkg::OP_DUP: begin
          if ((op_q == sbie_pkg::OP_LDLOC || op_q == sbie_pkg::OP_LDREF) && !idx_ok) begin
            flt_d = sbie_pkg::FLT_LOCAL;
          end else if (op_q == sbie_pkg::OP_DUP && cnt_q == '0) begin
            flt_d = sbie_pkg::FLT_UNDER;
          end else if (cnt_q >= CntW'(StackDepth)) begin
            flt_d = sbie_pkg::FLT_OVER;
          end else begin
            ctl.push = 1'b1;
            cnt_d    = cnt_q + 1'b1;
            case (op_q)
              sbie_pkg::OP_PUSHC: top_new = WordBits'($signed(imm_q));
              sbie_pkg::OP_DUP:   top_new = t0;
              sbie_pkg::OP_NIL:   top_new = '0;
              default:            top_new = loc_q[idx];
            endcase
          end
        end
        sbie_pkg::OP_STLOC: begin
          if (cnt_q == '0) flt_d = sbie_pkg::FLT_UNDER;
          else if (!idx_ok) flt_d = sbie_pkg::FLT_LOCAL;
          else begin
            loc_we  = 1'b1;
            ctl.pop = 1'b1;
            cnt_d   = cnt_q - 1'b1;
          end
        end
        sbie_pkg::OP_MUL, sbie_pkg::OP_ADD, sbie_pkg::OP_SUB, sbie_pkg::OP_DIV,
        sbie_pkg::OP_REM, sbie_pkg::OP_AND, sbie_pkg::OP_CGT, sbie_pkg::OP_CGE,
        sbie_pkg::OP_CLT, sbie_pkg::OP_CLE, sbie_pkg::OP_CNE, sbie_pkg::OP_CEQ: begin
          if (cnt_q < CntW'(2)) begin
            flt_d = sbie_pkg::FLT_UNDER;
          end else if ((op_q == sbie_pkg::OP_DIV || op_q == sbie_pkg::OP_REM)) begin
            if (t0 == '0) begin
              flt_d      = sbie_pkg::FLT_DIVZ;
              ctl.pop    = 1'b1;
              ctl.wr_top = 1'b1;
              cnt_d      = cnt_q - 1'b1;
            end else begin
              div_start = 1'b1;
            end
          end else begin
            ctl.pop    = 1'b1;
            ctl.wr_top = 1'b1;
            cnt_d      = cnt_q - 1'b1;
            case (op_q)
              sbie_pkg::OP_MUL: top_new = t1 * t0;
              sbie_pkg::OP_ADD: top_new = t1 + t0;
              sbie_pkg::OP_SUB: top_new = t1 - t0;
              sbie_pkg::OP_AND: top_new = WordBits'(slt('0, t1) && slt('0, t0));
              sbie_pkg::OP_CGT: top_new = WordBits'(slt(t0, t1));
              sbie_pkg::OP_CGE: top_new = WordBits'(!slt(t1, t0));
              sbie_pkg::OP_CLT: top_new = WordBits'(slt(t1, t0));
              sbie_pkg::OP_CLE: top_new = WordBits'(!slt(t0, t1));
              sbie_pkg::OP_CNE: top_new = WordBits'(t1 != t0);
              default:          top_new = WordBits'(t1 == t0);
            endcase
          end
        end
        sbie_pkg::OP_NEG: begin
          if (cnt_q == '0) flt_d = sbie_pkg::FLT_UNDER;
          else begin
            ctl.wr_top = 1'b1;
            top_new    = -t0;
          end
        end
        sbie_pkg::OP_IFLE: begin
          if (cnt_q == '0) flt_d = sbie_pkg::FLT_UNDER;
          else begin
            taken_d = slt(t0, WordBits'(1));
            ctl.pop = 1'b1;
            cnt_d   = cnt_q - 1'b1;
          end
        end
        sbie_pkg::OP_GOTO: taken_d = 1'b1;
        sbie_pkg::OP_IRET: begin
          ret_d = 1'b1;
          if (cnt_q == '0) flt_d = sbie_pkg::FLT_UNDER;
          else rv_d = t0;
        end
        sbie_pkg::OP_RET: ret_d = 1'b1;
        default: ;
      endcase
    end else if (state_q == sbie_pkg::ST_DIV && div_done) begin
      ctl.pop    = 1'b1;
      ctl.wr_top = 1'b1;
      cnt_d      = cnt_q - 1'b1;
      top_new    = (op_q == sbie_pkg::OP_DIV) ? quo : rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbie_pkg::ST_IDLE;
      cnt_q   <= '0;
      taken_q <= 1'b0;
      ret_q   <= 1'b0;
      rv_q    <= '0;
      flt_q   <= sbie_pkg::FLT_NONE;
      for (int i = 0; i < LocalSlots; i++) loc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      taken_q <= taken_d;
      ret_q   <= ret_d;
      rv_q    <= rv_d;
      flt_q   <= flt_d;
      if (loc_we) loc_q[idx] <= t0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      imm_q <= imm_i;
    end
  end

  assign out_valid_o    = (state_q == sbie_pkg::ST_OUT);
  assign top_value_o    = (cnt_q == '0) ? 32'sd0 : 32'($signed(t0));
  assign depth_o        = Dw'(cnt_q);
  assign branch_taken_o = taken_q;
  assign returned_o     = ret_q;
  assign return_value_o = 32'($signed(rv_q));
  assign fault_o        = flt_q;

  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(StackDepth)) else $error("stack count past depth");
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o) else $error("result repeated");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !out_valid_o && $stable(cnt_q)) else $error("accepted while busy");
endmodule

FILE: tb/sv/stack_bytecode_integer_executor_tb.sv
// Testbench for the integer stack-bytecode executor: directed table, an overflow fill, then random
// bytecode runs checked against a built-in stack/locals predictor. Uses sbie_pkg.
`timescale 1ns / 1ps
module stack_bytecode_integer_executor_tb;

  localparam int Depth = sbie_pkg::StackDepthDef;
  localparam int Slots = sbie_pkg::LocalSlotsDef;
  localparam int SlotW = $clog2(Slots);
  localparam int Dw    = sbie_pkg::DepthW;
  localparam int NRows = 25;

  typedef struct packed {
    logic signed [31:0]          top;
    logic [sbie_pkg::DepthW-1:0] depth;
    logic                        taken;
    logic                        ret;
    logic signed [31:0]          rval;
    logic [sbie_pkg::FaultW-1:0] fault;
  } result_t;

  typedef struct {
    logic [sbie_pkg::OpW-1:0] op;
    logic signed [31:0]       imm;
    bit                       has_exp;
    result_t                  exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [sbie_pkg::OpW-1:0] op_i = '0;
  logic signed [sbie_pkg::ImmW-1:0] imm_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] top_value_o, return_value_o;
  logic [sbie_pkg::DepthW-1:0] depth_o;
  logic branch_taken_o, returned_o;
  logic [sbie_pkg::FaultW-1:0] fault_o;

  stack_bytecode_integer_executor dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic signed [31:0] opstack [Depth];
  logic signed [31:0] locals [Slots];
  int unsigned sp;
  result_t results_due [$];
  int errors = 0;
  int beats_in = 0, beats_out = 0, faults_seen = 0, branches_seen = 0;
  int stall_left = 0;
  bit hold_out = 1'b0;
  bit sending = 1'b1;

  function automatic result_t execute_bytecode(logic [sbie_pkg::OpW-1:0] op,
                                               logic signed [31:0] imm);
    result_t r;
    logic signed [31:0] l, rt, v;
    bit ok;
    r = '0;
    ok = (imm >= 0) && (imm < Slots);
    v = '0;
    case (op)
      sbie_pkg::OP_PUSHC, sbie_pkg::OP_NIL, sbie_pkg::OP_LDLOC, sbie_pkg::OP_LDREF,
      sbie_pkg::OP_DUP: begin
        if ((op == sbie_pkg::OP_LDLOC || op == sbie_pkg::OP_LDREF) && !ok)
          r.fault = sbie_pkg::FLT_LOCAL;
        else if (op == sbie_pkg::OP_DUP && sp < 1) r.fault = sbie_pkg::FLT_UNDER;
        else if (sp >= Depth) r.fault = sbie_pkg::FLT_OVER;
        else begin
          if (op == sbie_pkg::OP_PUSHC) v = imm;
          else if (op == sbie_pkg::OP_LDLOC || op == sbie_pkg::OP_LDREF)
            v = locals[imm[SlotW-1:0]];
          else if (op == sbie_pkg::OP_DUP) v = opstack[sp-1];
          opstack[sp] = v;
          sp++;
        end
      end
      sbie_pkg::OP_STLOC: begin
        if (sp < 1) r.fault = sbie_pkg::FLT_UNDER;
        else if (!ok) r.fault = sbie_pkg::FLT_LOCAL;
        else begin
          locals[imm[SlotW-1:0]] = opstack[sp-1];
          sp--;
        end
      end
      sbie_pkg::OP_MUL, sbie_pkg::OP_ADD, sbie_pkg::OP_SUB, sbie_pkg::OP_DIV,
      sbie_pkg::OP_REM, sbie_pkg::OP_AND, sbie_pkg::OP_CGT, sbie_pkg::OP_CGE,
      sbie_pkg::OP_CLT, sbie_pkg::OP_CLE, sbie_pkg::OP_CNE, sbie_pkg::OP_CEQ: begin
        if (sp < 2) r.fault = sbie_pkg::FLT_UNDER;
        else begin
          rt = opstack[sp-1];
          l = opstack[sp-2];
          case (op)
            sbie_pkg::OP_MUL: v = l * rt;
            sbie_pkg::OP_ADD: v = l + rt;
            sbie_pkg::OP_SUB: v = l - rt;
            sbie_pkg::OP_DIV, sbie_pkg::OP_REM: begin
              if (rt == 0) r.fault = sbie_pkg::FLT_DIVZ;
              else if (l == 32'sh80000000 && rt == -1)
                v = (op == sbie_pkg::OP_DIV) ? l : 0;
              else v = (op == sbie_pkg::OP_DIV) ? l / rt : l % rt;
            end
            sbie_pkg::OP_AND: v = (l > 0 && rt > 0);
            sbie_pkg::OP_CGT: v = (l > rt);
            sbie_pkg::OP_CGE: v = (l >= rt);
            sbie_pkg::OP_CLT: v = (l < rt);
            sbie_pkg::OP_CLE: v = (l <= rt);
            sbie_pkg::OP_CNE: v = (l != rt);
            default: v = (l == rt);
          endcase
          opstack[sp-2] = v;
          sp--;
        end
      end
      sbie_pkg::OP_NEG: begin
        if (sp < 1) r.fault = sbie_pkg::FLT_UNDER;
        else opstack[sp-1] = -opstack[sp-1];
      end
      sbie_pkg::OP_IFLE: begin
        if (sp < 1) r.fault = sbie_pkg::FLT_UNDER;
        else begin
          r.taken = (opstack[sp-1] < 1);
          sp--;
        end
      end
      sbie_pkg::OP_GOTO: r.taken = 1'b1;
      sbie_pkg::OP_IRET: begin
        r.ret = 1'b1;
        if (sp < 1) r.fault = sbie_pkg::FLT_UNDER;
        else r.rval = opstack[sp-1];
      end
      sbie_pkg::OP_RET: r.ret = 1'b1;
      default: ;
    endcase
    r.depth = Dw'(sp);
    r.top = (sp > 0) ? opstack[sp-1] : 32'sd0;
    return r;
  endfunction

  task automatic send_bytecode(logic [sbie_pkg::OpW-1:0] op, logic signed [31:0] imm,
                               bit has_exp = 0, result_t exp = '0);
    result_t p;
    p = execute_bytecode(op, imm);
    if (has_exp && p != exp)
      $display("%0t table row mismatch op %0d: expected %h predicted %h",
               $time, op, exp, p);
    if (has_exp && p != exp) errors++;
    results_due = {results_due, p};
    in_valid_i <= 1'b1;
    op_i <= op;
    imm_i <= imm;
    do @(posedge clk_i); while (in_stall_o);
    beats_in++;
    @(negedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      op_i <= 5'($urandom);
      imm_i <= $urandom;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(negedge clk_i);
    end
  endtask

  function automatic result_t mk(int top, int d, bit t = 0, bit rt = 0, int rv = 0,
                                 logic [sbie_pkg::FaultW-1:0] f = sbie_pkg::FLT_NONE);
    result_t r;
    r.top = top; r.depth = Dw'(d); r.taken = t; r.ret = rt; r.rval = rv; r.fault = f;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return -$signed(32'($urandom_range(1, 3)));
      2: return 32'sh80000000;
      3: return 32'sh7fffffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [sbie_pkg::OpW-1:0] rand_op();
    if (sp < 2 && $urandom_range(0, 2) != 0) return sbie_pkg::OP_PUSHC;
    if (sp > Depth - 4 && $urandom_range(0, 1) == 0) return sbie_pkg::OP_ADD;
    return $urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(0, 22));
  endfunction

  function automatic logic signed [31:0] rand_imm(logic [sbie_pkg::OpW-1:0] op);
    if (op inside {sbie_pkg::OP_STLOC, sbie_pkg::OP_LDLOC, sbie_pkg::OP_LDREF}) begin
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? $urandom : -1;
      return $urandom_range(0, Slots - 1);
    end
    return rand_word();
  endfunction

  // receiver: sample at rising edge, stall chosen at falling edge
  always @(posedge clk_i) begin
    result_t got, exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {top_value_o, depth_o, branch_taken_o, returned_o, return_value_o, fault_o};
      beats_out++;
      if (got.fault != sbie_pkg::FLT_NONE) faults_seen++;
      if (got.taken) branches_seen++;
      if (results_due.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, got);
        errors++;
      end else begin
        exp = results_due.pop_front();
        if (got !== exp) begin
          $display("%0t mismatch: expected top %0d depth %0d tk %b ret %b rv %0d flt %0d",
                   $time, exp.top, exp.depth, exp.taken, exp.ret, exp.rval, exp.fault);
          $display("%0t            actual top %0d depth %0d tk %b ret %b rv %0d flt %0d",
                   $time, got.top, got.depth, got.taken, got.ret, got.rval, got.fault);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_out) begin
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (sending && $urandom_range(0, 4) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    repeat (400000) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t rows [NRows];
    for (int i = 0; i < Depth; i++) opstack[i] = 0;
    for (int i = 0; i < Slots; i++) locals[i] = 0;
    sp = 0;
    rows = '{
      '{sbie_pkg::OP_ADD, 0, 1, mk(0, 0, 0, 0, 0, sbie_pkg::FLT_UNDER)},
      '{sbie_pkg::OP_IRET, 0, 1, mk(0, 0, 0, 1, 0, sbie_pkg::FLT_UNDER)},
      '{sbie_pkg::OP_STLOC, 3, 1, mk(0, 0, 0, 0, 0, sbie_pkg::FLT_UNDER)},
      '{sbie_pkg::OP_LDLOC, 15, 1, mk(0, 1)},
      '{sbie_pkg::OP_LDLOC, 16, 1, mk(0, 1, 0, 0, 0, sbie_pkg::FLT_LOCAL)},
      '{sbie_pkg::OP_LDREF, -1, 1, mk(0, 1, 0, 0, 0, sbie_pkg::FLT_LOCAL)},
      '{sbie_pkg::OP_PUSHC, 32'sh80000000, 1, mk(32'sh80000000, 2)},
      '{sbie_pkg::OP_PUSHC, -1, 1, mk(-1, 3)},
      '{sbie_pkg::OP_DIV, 0, 1, mk(32'sh80000000, 2)},
      '{sbie_pkg::OP_PUSHC, -1, 0, '0},
      '{sbie_pkg::OP_REM, 0, 1, mk(0, 2)},
      '{sbie_pkg::OP_PUSHC, 0, 0, '0},
      '{sbie_pkg::OP_DIV, 0, 1, mk(0, 2, 0, 0, 0, sbie_pkg::FLT_DIVZ)},
      '{sbie_pkg::OP_PUSHC, 32'sh7fffffff, 0, '0},
      '{sbie_pkg::OP_DUP, 0, 0, '0}, '{sbie_pkg::OP_MUL, 0, 0, '0},
      '{sbie_pkg::OP_NEG, 0, 0, '0}, '{sbie_pkg::OP_STLOC, 0, 0, '0},
      '{sbie_pkg::OP_LDREF, 0, 0, '0}, '{sbie_pkg::OP_CGE, 0, 0, '0},
      '{sbie_pkg::OP_IFLE, 7, 0, '0}, '{sbie_pkg::OP_GOTO, -5, 1, mk(0, 1, 1)},
      '{sbie_pkg::OP_IRET, 0, 1, mk(0, 1, 0, 1, 0)},
      '{sbie_pkg::OP_RET, 0, 1, mk(0, 1, 0, 1)},
      '{5'd31, 0, 1, mk(0, 1)}
    };
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) send_bytecode(rows[i].op, rows[i].imm, rows[i].has_exp, rows[i].exp);
    // fill to overflow under a long receiver hold
    hold_out = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        hold_out = 1'b0;
      end
      for (int i = 0; i < Depth + 2; i++) send_bytecode(sbie_pkg::OP_PUSHC, rand_word());
    join
    for (int i = 0; i < 6; i++)
      send_bytecode(5'($urandom_range(sbie_pkg::OP_CGT, sbie_pkg::OP_CEQ)), 0);
    for (int i = 0; i < 800; i++) begin
      logic [sbie_pkg::OpW-1:0] op;
      op = rand_op();
      send_bytecode(op, rand_imm(op));
    end
    in_valid_i <= 1'b0;
    sending = 1'b0;
    wait (results_due.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d bytecodes, %0d results, %0d faults and %0d taken branches.",
             beats_in, beats_out, faults_seen, branches_seen);
    if (errors == 0 && results_due.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
